/* rtl/ptcvm_pkg.sv */
package ptcvm_pkg;

  localparam int unsigned TableLen = 24;
  localparam int unsigned TurnQ6 = 23040;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic [1:0] RowTrans = 2'd3;

  typedef logic signed [33:0] cq_t;
  typedef logic signed [32:0] ang_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] r;
    begin
      unique case (idx)
        5'd0: r = 32'd536870912;
        5'd1: r = 32'd316933406;
        5'd2: r = 32'd167458907;
        5'd3: r = 32'd85004756;
        5'd4: r = 32'd42667331;
        5'd5: r = 32'd21354465;
        5'd6: r = 32'd10679838;
        5'd7: r = 32'd5340245;
        5'd8: r = 32'd2670163;
        5'd9: r = 32'd1335087;
        5'd10: r = 32'd667544;
        5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;
        5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;
        5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;
        5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;
        5'd19: r = 32'd1304;
        5'd20: r = 32'd652;
        5'd21: r = 32'd326;
        5'd22: r = 32'd163;
        5'd23: r = 32'd81;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    begin
      if (v > 64'sd2147483647) r = 32'sh7fffffff;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
    end
  endfunction

endpackage

/* rtl/pan_tilt_camera_view_matrix.sv */
// channel  | direction | handshake         | payload
// pose     | in        | start / busy      | pan_angle_i tilt_angle_i pos_x_i pos_y_i pos_z_i
// row      | out       | row_valid_o       | row_index_o col_*_o last_row_o
// a pose is taken only while busy is low; busy is raised after each accepted start
// row 0 is on the ports after the angle register, the CORDIC stages and stages a to d; rows 1 to 3 follow
// the pipeline advances one step per cycle, rate is set by the single row port
// reset clears valid bits and the row sequencer; rows cannot be stalled
module pan_tilt_camera_view_matrix #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] pan_angle_i,
  input  logic signed [15:0] tilt_angle_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  output logic               row_valid_o,
  output logic [1:0]         row_index_o,
  output logic signed [31:0] col_right_o,
  output logic signed [31:0] col_up_o,
  output logic signed [31:0] col_look_o,
  output logic               last_row_o
);
  localparam int unsigned N = (CORDIC_STEPS > ptcvm_pkg::TableLen) ?
                              ptcvm_pkg::TableLen : CORDIC_STEPS;
  localparam int unsigned D = N + 1;

  logic [1:0] gap_q;
  logic acc;
  assign busy = (gap_q != 2'd0);
  assign acc = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) gap_q <= '0;
    else if (acc) gap_q <= 2'd3;
    else if (busy) gap_q <= gap_q - 2'd1;
  end

  // angle stage and cordic run every cycle
  ptcvm_pkg::ang_t zp, zt;
  logic fp, ft;
  ptcvm_pkg::cq_t sp, cp, st, ct;

  ptcvm_angle u_pan (.clk_i, .rst_ni, .en_i(1'b1), .deg_i(pan_angle_i),
                     .z_o(zp), .flip_o(fp));
  ptcvm_angle u_tilt (.clk_i, .rst_ni, .en_i(1'b1), .deg_i(tilt_angle_i),
                      .z_o(zt), .flip_o(ft));
  ptcvm_cordic #(.CordicSteps(CORDIC_STEPS)) u_cp (.clk_i, .rst_ni, .en_i(1'b1),
    .z_i(zp), .flip_i(fp), .sin_o(sp), .cos_o(cp));
  ptcvm_cordic #(.CordicSteps(CORDIC_STEPS)) u_ct (.clk_i, .rst_ni, .en_i(1'b1),
    .z_i(zt), .flip_i(ft), .sin_o(st), .cos_o(ct));

  // valid and position delay line
  logic v_q [D];
  logic signed [31:0] px_q [D];
  logic signed [31:0] py_q [D];
  logic signed [31:0] pz_q [D];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < D; k++) v_q[k] <= 1'b0;
    end else begin
      v_q[0] <= acc;
      for (int k = 1; k < D; k++) v_q[k] <= v_q[k-1];
    end
  end
  always_ff @(posedge clk_i) begin
    px_q[0] <= pos_x_i;
    py_q[0] <= pos_y_i;
    pz_q[0] <= pos_z_i;
    for (int k = 1; k < D; k++) begin
      px_q[k] <= px_q[k-1];
      py_q[k] <= py_q[k-1];
      pz_q[k] <= pz_q[k-1];
    end
  end
  // v_q[0] aligns with angle register; cordic outputs align with v_q[D-1]
  logic vc;
  assign vc = v_q[D-1];

  // stage a: products and single conversions
  logic va_q;
  logic signed [67:0] p_ctsp_q, p_ctcp_q, p_stsp_q, p_stcp_q;
  logic signed [31:0] rx_q, rz_q, uy_q, ly_q;
  logic signed [31:0] ax_q, ay_q, az_q;
  function automatic logic signed [31:0] q30(input ptcvm_pkg::cq_t v);
    logic signed [34:0] t;
    begin
      t = 35'(v) + 35'sd8192;
      return 32'(t >>> 14);
    end
  endfunction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else va_q <= vc;
  end
  always_ff @(posedge clk_i) begin
    p_ctsp_q <= 68'(ct) * 68'(sp);
    p_ctcp_q <= 68'(ct) * 68'(cp);
    p_stsp_q <= 68'(st) * 68'(sp);
    p_stcp_q <= 68'(st) * 68'(cp);
    rx_q <= q30(cp);
    rz_q <= -q30(sp);
    uy_q <= q30(ct);
    ly_q <= -q30(st);
    ax_q <= px_q[D-1];
    ay_q <= py_q[D-1];
    az_q <= pz_q[D-1];
  end

  // stage b: round products
  function automatic logic signed [31:0] q60(input logic signed [67:0] p);
    logic signed [67:0] t;
    begin
      t = p + 68'sd8796093022208;
      return 32'(t >>> 44);
    end
  endfunction
  logic vb_q;
  logic signed [31:0] r0, r2, u0, u1, u2, l0, l1, l2;
  logic signed [31:0] bx_q, by_q, bz_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else vb_q <= va_q;
  end
  always_ff @(posedge clk_i) begin
    l0 <= q60(p_ctsp_q);
    l2 <= q60(p_ctcp_q);
    u0 <= q60(p_stsp_q);
    u2 <= q60(p_stcp_q);
    r0 <= rx_q;
    r2 <= rz_q;
    u1 <= uy_q;
    l1 <= ly_q;
    bx_q <= ax_q;
    by_q <= ay_q;
    bz_q <= az_q;
  end

  // stage c: axis by position products
  logic vcc_q;
  logic signed [63:0] m [9];
  logic signed [31:0] hr0, hr2, hu0, hu1, hu2, hl0, hl1, hl2;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vcc_q <= 1'b0;
    else vcc_q <= vb_q;
  end
  always_ff @(posedge clk_i) begin
    m[0] <= 64'(r0) * 64'(bx_q);
    m[1] <= 64'(r2) * 64'(bz_q);
    m[2] <= 64'(u0) * 64'(bx_q);
    m[3] <= 64'(u1) * 64'(by_q);
    m[4] <= 64'(u2) * 64'(bz_q);
    m[5] <= 64'(l0) * 64'(bx_q);
    m[6] <= 64'(l1) * 64'(by_q);
    m[7] <= 64'(l2) * 64'(bz_q);
    m[8] <= '0;
    hr0 <= r0; hr2 <= r2; hu0 <= u0; hu1 <= u1; hu2 <= u2;
    hl0 <= l0; hl1 <= l1; hl2 <= l2;
  end

  // stage d: sums and translation, then hold for row output
  logic vd_q;
  logic signed [31:0] t0_q, t1_q, t2_q;
  logic signed [31:0] gr0, gr2, gu0, gu1, gu2, gl0, gl1, gl2;
  function automatic logic signed [31:0] tr(input logic signed [65:0] s);
    logic signed [65:0] t;
    begin
      t = -((s + 66'sd32768) >>> 16);
      return ptcvm_pkg::sat32(64'(t));
    end
  endfunction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vd_q <= 1'b0;
    else vd_q <= vcc_q;
  end
  always_ff @(posedge clk_i) begin
    if (vcc_q) begin
      t0_q <= tr(66'(m[0]) + 66'(m[1]) + 66'(m[8]));
      t1_q <= tr(66'(m[2]) + 66'(m[3]) + 66'(m[4]));
      t2_q <= tr(66'(m[5]) + 66'(m[6]) + 66'(m[7]));
      gr0 <= hr0; gr2 <= hr2; gu0 <= hu0; gu1 <= hu1; gu2 <= hu2;
      gl0 <= hl0; gl1 <= hl1; gl2 <= hl2;
    end
  end

  // row sequencer
  logic [1:0] row_q;
  logic act_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      act_q <= 1'b0;
    end else if (vd_q) begin
      row_q <= 2'd1;
      act_q <= 1'b1;
    end else if (act_q) begin
      row_q <= row_q + 2'd1;
      act_q <= (row_q != ptcvm_pkg::RowTrans);
    end
  end

  logic [1:0] cur;
  assign cur = vd_q ? 2'd0 : row_q;
  assign row_valid_o = vd_q || (act_q && row_q != 2'd0);
  assign row_index_o = cur;
  assign last_row_o = (cur == ptcvm_pkg::RowTrans);
  always_comb begin
    unique case (cur)
      2'd0: begin col_right_o = gr0; col_up_o = gu0; col_look_o = gl0; end
      2'd1: begin col_right_o = '0; col_up_o = gu1; col_look_o = gl1; end
      2'd2: begin col_right_o = gr2; col_up_o = gu2; col_look_o = gl2; end
      default: begin col_right_o = t0_q; col_up_o = t1_q; col_look_o = t2_q; end
    endcase
  end

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> busy) else $error("busy not raised after start");
  a_row0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vd_q |-> row_index_o == 2'd0) else $error("row order broken");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_valid_o && last_row_o) |=> !(act_q && row_q != 2'd0))
    else $error("extra row after last");
endmodule

/* rtl/ptcvm_angle.sv */
module ptcvm_angle (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic signed [15:0]  deg_i,
  output ptcvm_pkg::ang_t     z_o,
  output logic                flip_o
);
  // reduce into one turn, then map to binary turn fraction by constant multiply
  logic [15:0] red_q;
  logic signed [16:0] dext;
  logic signed [16:0] red_d;
  logic [32:0] zt;
  logic signed [33:0] zs;
  logic signed [33:0] zf;

  always_comb begin
    dext = {deg_i[15], deg_i};
    if (dext >= 17'sd23040) red_d = dext - 17'sd23040;
    else if (dext < 0 && dext >= -17'sd23040) red_d = dext + 17'sd23040;
    else if (dext < -17'sd23040) red_d = dext + 17'sd46080;
    else red_d = dext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q <= '0;
    end else if (en_i) begin
      red_q <= red_d[15:0];
    end
  end

  // round(a*2^32/23040) = floor((a*2^24 + 45)/90), with 2^23 = 45*186413 + 23
  // this is a*186413 + floor((46a + 45)/90), the small quotient by reciprocal
  logic [33:0] base;
  logic [20:0] n;
  logic [42:0] qn;
  always_comb begin
    base = 34'(red_q) * 34'd186413;
    n = 21'(red_q) * 21'd46 + 21'd45;
    qn = 43'(n) * 43'd2982617;
    zt = 33'(base + 34'(qn >> 28));
    zs = {1'b0, zt};
    if (zs >= 34'sd2147483648) zs = zs - 34'sd4294967296;
    zf = zs;
    flip_o = 1'b0;
    if (zs > 34'sd1073741824) begin
      zf = zs - 34'sd2147483648;
      flip_o = 1'b1;
    end else if (zs < -34'sd1073741824) begin
      zf = zs + 34'sd2147483648;
      flip_o = 1'b1;
    end
    z_o = zf[32:0];
  end
endmodule

/* rtl/ptcvm_cordic.sv */
module ptcvm_cordic #(
  parameter int unsigned CordicSteps = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  ptcvm_pkg::ang_t   z_i,
  input  logic              flip_i,
  output ptcvm_pkg::cq_t    sin_o,
  output ptcvm_pkg::cq_t    cos_o
);
  localparam int unsigned N = (CordicSteps > ptcvm_pkg::TableLen) ?
                              ptcvm_pkg::TableLen : CordicSteps;

  ptcvm_pkg::cq_t x_q [N+1];
  ptcvm_pkg::cq_t y_q [N+1];
  ptcvm_pkg::ang_t z_q [N+1];
  logic f_q [N+1];

  always_comb begin
    x_q[0] = ptcvm_pkg::CordicGain;
    y_q[0] = '0;
    z_q[0] = z_i;
    f_q[0] = flip_i;
  end

  for (genvar i = 0; i < N; i++) begin : g_st
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][32]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - $signed({1'b0, ptcvm_pkg::atan_turn(5'(i))});
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + $signed({1'b0, ptcvm_pkg::atan_turn(5'(i))});
        end
        f_q[i+1] <= f_q[i];
      end
    end
  end

  assign cos_o = f_q[N] ? -x_q[N] : x_q[N];
  assign sin_o = f_q[N] ? -y_q[N] : y_q[N];

  logic unused;
  assign unused = rst_ni;
endmodule
